@@ src/ius_pkg.sv @@
`timescale 1ns / 1ps

package ius_pkg;

	localparam int WIN_LIMIT = 4096;

	localparam int CFG_W   = 13;
	localparam int REQ_W   = 3;
	localparam int COL_W   = 9;
	localparam int ROW_W   = 8;
	localparam int COLOR_W = 32;
	localparam int WIN_W   = 12;
	localparam int ADDR_W  = 24;

	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 80;

	localparam logic [1:0] REG_WINDOW_WIDTH    = 2'd0;
	localparam logic [1:0] REG_WINDOW_HEIGHT   = 2'd1;
	localparam logic [1:0] REG_REQUESTED_SCALE = 2'd2;

	localparam logic [CFG_W-1:0] RST_WINDOW_WIDTH    = 13'd640;
	localparam logic [CFG_W-1:0] RST_WINDOW_HEIGHT   = 13'd480;
	localparam logic [REQ_W-1:0] RST_REQUESTED_SCALE = 3'd2;

	typedef struct packed {
		logic [WIN_W-1:0]   col;
		logic [WIN_W-1:0]   row;
		logic [COLOR_W-1:0] color;
		logic               last;
	} ius_copy_t;

endpackage

@@ src/ius_expander.sv @@
`timescale 1ns / 1ps

module ius_expander
	import ius_pkg::*;
#(
	parameter int SW = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [WIN_W-1:0]   dx0,
	input  logic [WIN_W-1:0]   dy0,
	input  logic [COLOR_W-1:0] color,
	input  logic [SW-1:0]      ncols,
	input  logic [SW-1:0]      nrows,
	output logic               out_valid,
	input  logic               out_ready,
	output ius_copy_t          out_copy
);

	logic               busy_q;
	logic [SW-1:0]      cx_q;
	logic [SW-1:0]      cy_q;
	logic [WIN_W-1:0]   dx0_q;
	logic [WIN_W-1:0]   dy0_q;
	logic [COLOR_W-1:0] color_q;
	logic [SW-1:0]      ncols_q;
	logic [SW-1:0]      nrows_q;

	logic fire;
	logic row_end;
	logic is_last;
	logic load;

	assign row_end   = (cx_q == ncols_q - SW'(1));
	assign is_last   = row_end && (cy_q == nrows_q - SW'(1));
	assign fire      = busy_q && out_ready;
	assign in_ready  = !busy_q || (out_ready && is_last);
	assign load      = in_valid && in_ready;
	assign out_valid = busy_q;

	always_comb begin
		out_copy.col   = dx0_q + WIN_W'(cx_q);
		out_copy.row   = dy0_q + WIN_W'(cy_q);
		out_copy.color = color_q;
		out_copy.last  = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cx_q   <= '0;
			cy_q   <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cx_q   <= '0;
			cy_q   <= '0;
		end else if (fire) begin
			if (is_last) begin
				busy_q <= 1'b0;
			end
			if (row_end) begin
				cx_q <= '0;
				cy_q <= cy_q + SW'(1);
			end else begin
				cx_q <= cx_q + SW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dx0_q   <= dx0;
			dy0_q   <= dy0;
			color_q <= color;
			ncols_q <= ncols;
			nrows_q <= nrows;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cx_q < ncols_q) && (cy_q < nrows_q))
		else $error("copy counters beyond span");
	a_no_empty_span: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> (ncols != '0) && (nrows != '0))
		else $error("empty span offered to expander");
	a_load_restart: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy_q && (cx_q == '0) && (cy_q == '0))
		else $error("span load did not restart counters");
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && is_last && !in_valid) |=> !busy_q)
		else $error("expander still busy after last copy");
`endif

endmodule

@@ src/integer_upscale_blit_addresser_top.sv @@
`timescale 1ns / 1ps

// nearest-neighbour integer upscaler with blit addressing
// s_* channel: one source pixel per item, tdata = {color, row, col} from the lsb
// m_* channel: one destination copy per item, tlast on the final copy of a pixel
// cfg_*: window width, window height and requested scale, written while idle
// an accepted pixel runs through stages 1 to 4 and the copy generator, which puts
// the pixel's first copy in the output register; it emits one copy per cycle while
// the output register accepts, scale*scale copies per pixel less clipped ones, four
// at the default scale of two; out-of-frame or fully clipped pixels are dropped
// before the copy generator and give no output
// back-to-back pixels overlap: front stages fill while copies of earlier ones drain
// reset clears all valid bits and loads 640 x 480 at scale 2
// when m_tready is low the output register holds, the copy generator pauses
// and s_tready falls once every front stage is full; nothing is lost or repeated

module integer_upscale_blit_addresser_top
	import ius_pkg::*;
#(
	parameter int SRC_WIDTH  = 320,
	parameter int SRC_HEIGHT = 200,
	parameter int MAX_SCALE  = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wen,
	input  logic [1:0]             cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // src_col, src_row, src_color, zero pad
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // win_col, win_row, pixel_address, out_color
	output logic                   m_tlast
);

	localparam int SW  = $clog2(MAX_SCALE + 1);
	localparam int FW  = SW;
	localparam int XW  = $clog2(WIN_LIMIT + SRC_WIDTH * MAX_SCALE + 1);
	localparam int YW  = $clog2(WIN_LIMIT + SRC_HEIGHT * MAX_SCALE + 1);

	localparam logic [CFG_W-1:0] WIN_MAX = CFG_W'(WIN_LIMIT);
	localparam logic [COL_W+1:0] SRC_W_L = (COL_W + 2)'(SRC_WIDTH);
	localparam logic [ROW_W+2:0] SRC_H_L = (ROW_W + 3)'(SRC_HEIGHT);
	localparam logic [3:0]       MAX_S_L = 4'(MAX_SCALE);
	localparam logic [XW-1:0]    SRC_W_X = XW'(SRC_WIDTH);
	localparam logic [YW-1:0]    SRC_H_Y = YW'(SRC_HEIGHT);

	// configuration
	logic [CFG_W-1:0] win_w_q;
	logic [CFG_W-1:0] win_h_q;
	logic [REQ_W-1:0] req_q;
	logic [CFG_W-1:0] w_sat;
	logic [CFG_W-1:0] h_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_w_q <= RST_WINDOW_WIDTH;
			win_h_q <= RST_WINDOW_HEIGHT;
			req_q   <= RST_REQUESTED_SCALE;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_WINDOW_WIDTH:    win_w_q <= cfg_data;
				REG_WINDOW_HEIGHT:   win_h_q <= cfg_data;
				REG_REQUESTED_SCALE: req_q   <= cfg_data[REQ_W-1:0];
				default: ;
			endcase
		end
	end

	assign w_sat = (win_w_q > WIN_MAX) ? WIN_MAX : win_w_q;
	assign h_sat = (win_h_q > WIN_MAX) ? WIN_MAX : win_h_q;

	// pipeline control
	logic v_s1, v_s2, v_s3, v_s4, v_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s6;
	logic exp_in_ready;
	logic exp_out_valid;
	ius_copy_t exp_copy;

	assign rdy_s6   = !v_s6 || m_tready;
	assign rdy_s4   = !v_s4 || exp_in_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;

	// stage 1: range checks, clamped request, whole-frame fits
	logic [COL_W-1:0]   in_col;
	logic [ROW_W-1:0]   in_row;
	logic [COLOR_W-1:0] in_color;
	logic               ok_c1;
	logic [3:0]         req_c1;
	logic [SW-1:0]      fitx_c1;
	logic [SW-1:0]      fity_c1;

	assign in_col   = s_tdata[COL_W-1:0];
	assign in_row   = s_tdata[COL_W+ROW_W-1:COL_W];
	assign in_color = s_tdata[COL_W+ROW_W+COLOR_W-1:COL_W+ROW_W];

	always_comb begin
		ok_c1 = (w_sat != '0) && (h_sat != '0) && ({2'b00, in_col} < SRC_W_L)
			&& ({3'b000, in_row} < SRC_H_L);
		req_c1 = {1'b0, req_q};
		if (req_c1 == 4'd0) begin
			req_c1 = 4'd1;
		end
		if (req_c1 > MAX_S_L) begin
			req_c1 = MAX_S_L;
		end
		// fits saturate at the largest scale, which is all the scale choice needs
		fitx_c1 = '0;
		fity_c1 = '0;
		for (int k = 1; k <= MAX_SCALE; k++) begin
			if (32'(w_sat) >= 32'(k * SRC_WIDTH)) begin
				fitx_c1 = SW'(k);
			end
			if (32'(h_sat) >= 32'(k * SRC_HEIGHT)) begin
				fity_c1 = SW'(k);
			end
		end
	end

	logic [COL_W-1:0]   col_s1, col_s2;
	logic [ROW_W-1:0]   row_s1, row_s2;
	logic [COLOR_W-1:0] color_s1, color_s2, color_s3, color_s4;
	logic               ok_s1, ok_s2, ok_s3;
	logic [SW-1:0]      req_s1;
	logic [SW-1:0]      fitx_s1;
	logic [SW-1:0]      fity_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			col_s1   <= in_col;
			row_s1   <= in_row;
			color_s1 <= in_color;
			ok_s1    <= ok_c1;
			req_s1   <= req_c1[SW-1:0];
			fitx_s1  <= fitx_c1;
			fity_s1  <= fity_c1;
		end
	end

	// stage 2: effective scale
	logic [FW-1:0] sc_c2;
	logic [FW-1:0] fit_c2;
	logic [FW-1:0] fx_c2;
	logic [FW-1:0] fy_c2;

	always_comb begin
		fx_c2  = FW'(fitx_s1);
		fy_c2  = FW'(fity_s1);
		sc_c2  = FW'(req_s1);
		fit_c2 = (fx_c2 < fy_c2) ? fx_c2 : fy_c2;
		if ((fx_c2 != '0) && (fy_c2 != '0) && (fit_c2 < sc_c2)) begin
			sc_c2 = fit_c2;
		end
		if (sc_c2 == '0) begin
			sc_c2 = FW'(1);
		end
		if ((32'(sc_c2) * 32'(SRC_WIDTH)) > 32'(w_sat)) begin
			sc_c2 = (fx_c2 == '0) ? FW'(1) : fx_c2;
		end
		if ((32'(sc_c2) * 32'(SRC_HEIGHT)) > 32'(h_sat)) begin
			sc_c2 = (fy_c2 == '0) ? FW'(1) : fy_c2;
		end
	end

	logic [SW-1:0] scale_s2, scale_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			col_s2   <= col_s1;
			row_s2   <= row_s1;
			color_s2 <= color_s1;
			ok_s2    <= ok_s1;
			scale_s2 <= sc_c2[SW-1:0];
		end
	end

	// stage 3: centring offsets and first copy position
	logic [XW-1:0] wx_c3, sizex_c3, offx_c3;
	logic [YW-1:0] hy_c3, sizey_c3, offy_c3;

	always_comb begin
		wx_c3    = XW'(w_sat);
		hy_c3    = YW'(h_sat);
		sizex_c3 = XW'(scale_s2) * SRC_W_X;
		sizey_c3 = YW'(scale_s2) * SRC_H_Y;
		offx_c3  = (wx_c3 > sizex_c3) ? ((wx_c3 - sizex_c3) >> 1) : '0;
		offy_c3  = (hy_c3 > sizey_c3) ? ((hy_c3 - sizey_c3) >> 1) : '0;
	end

	logic [XW-1:0] dx0_s3;
	logic [YW-1:0] dy0_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			color_s3 <= color_s2;
			ok_s3    <= ok_s2;
			scale_s3 <= scale_s2;
			dx0_s3   <= offx_c3 + XW'(col_s2) * XW'(scale_s2);
			dy0_s3   <= offy_c3 + YW'(row_s2) * YW'(scale_s2);
		end
	end

	// stage 4: visible span after clipping
	logic [XW-1:0] remx_c4;
	logic [YW-1:0] remy_c4;
	logic [SW-1:0] ncols_c4;
	logic [SW-1:0] nrows_c4;
	logic          keep_c4;

	always_comb begin
		remx_c4  = (dx0_s3 < XW'(w_sat)) ? (XW'(w_sat) - dx0_s3) : '0;
		remy_c4  = (dy0_s3 < YW'(h_sat)) ? (YW'(h_sat) - dy0_s3) : '0;
		ncols_c4 = (remx_c4 > XW'(scale_s3)) ? scale_s3 : remx_c4[SW-1:0];
		nrows_c4 = (remy_c4 > YW'(scale_s3)) ? scale_s3 : remy_c4[SW-1:0];
		keep_c4  = ok_s3 && (ncols_c4 != '0) && (nrows_c4 != '0);
	end

	logic [WIN_W-1:0] dx0_s4;
	logic [WIN_W-1:0] dy0_s4;
	logic [SW-1:0]    ncols_s4;
	logic [SW-1:0]    nrows_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy_s4) begin
			v_s4 <= v_s3 && keep_c4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			color_s4 <= color_s3;
			dx0_s4   <= dx0_s3[WIN_W-1:0];
			dy0_s4   <= dy0_s3[WIN_W-1:0];
			ncols_s4 <= ncols_c4;
			nrows_s4 <= nrows_c4;
		end
	end

	// copy generator
	ius_expander #(
		.SW (SW)
	) u_expander (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_ready  (exp_in_ready),
		.dx0       (dx0_s4),
		.dy0       (dy0_s4),
		.color     (color_s4),
		.ncols     (ncols_s4),
		.nrows     (nrows_s4),
		.out_valid (exp_out_valid),
		.out_ready (rdy_s6),
		.out_copy  (exp_copy)
	);

	// output register with linear address
	logic [WIN_W+CFG_W-1:0] addr_c6;
	ius_copy_t              copy_s6;
	logic [ADDR_W-1:0]      addr_s6;

	assign addr_c6 = ((WIN_W + CFG_W)'(exp_copy.row) * (WIN_W + CFG_W)'(w_sat))
		+ (WIN_W + CFG_W)'(exp_copy.col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (rdy_s6) begin
			v_s6 <= exp_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s6 && exp_out_valid) begin
			copy_s6 <= exp_copy;
			addr_s6 <= addr_c6[ADDR_W-1:0];
		end
	end

	assign m_tvalid = v_s6;
	assign m_tlast  = copy_s6.last;
	assign m_tdata  = {copy_s6.color, addr_s6, copy_s6.row, copy_s6.col};

endmodule

@@ tb/integer_upscale_blit_addresser_top_tb.sv @@
`timescale 1ns / 1ps

module integer_upscale_blit_addresser_top_tb;
	import ius_pkg::*;

	localparam int SRC_WIDTH  = 320;
	localparam int SRC_HEIGHT = 200;
	localparam int MAX_SCALE  = 4;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES  = 32;
	localparam int STALL_LIMIT    = 2000;

	typedef struct packed {
		logic [WIN_W-1:0]   col;
		logic [WIN_W-1:0]   row;
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] color;
		logic               last;
	} blit_copy_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_wen;
	logic [1:0]             cfg_index;
	logic [CFG_W-1:0]       cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;

	blit_copy_t       pending_copies[$];
	logic [CFG_W-1:0] win_width_reg;
	logic [CFG_W-1:0] win_height_reg;
	logic [REQ_W-1:0] scale_reg;
	int               error_count;
	int               quiet_cycles;
	bit               no_idle;

	integer_upscale_blit_addresser_top #(
		.SRC_WIDTH (SRC_WIDTH),
		.SRC_HEIGHT(SRC_HEIGHT),
		.MAX_SCALE (MAX_SCALE)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// copies of one source pixel under the current window settings
	function automatic void predict_copies(logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
			logic [COLOR_W-1:0] color);
		int unsigned w, h, scale, fit_x, fit_y, fit, off_x, off_y, dx, dy;
		int n;
		blit_copy_t c;
		w = (win_width_reg > WIN_LIMIT) ? WIN_LIMIT : win_width_reg;
		h = (win_height_reg > WIN_LIMIT) ? WIN_LIMIT : win_height_reg;
		n = 0;
		if (w == 0 || h == 0 || col >= SRC_WIDTH || row >= SRC_HEIGHT)
			return;
		scale = scale_reg;
		if (scale < 1)
			scale = 1;
		if (scale > MAX_SCALE)
			scale = MAX_SCALE;
		fit_x = w / SRC_WIDTH;
		fit_y = h / SRC_HEIGHT;
		if (fit_x > 0 && fit_y > 0) begin
			fit = (fit_x < fit_y) ? fit_x : fit_y;
			if (fit < scale)
				scale = fit;
		end
		if (scale < 1)
			scale = 1;
		if (scale * SRC_WIDTH > w)
			scale = (fit_x < 1) ? 1 : fit_x;
		if (scale * SRC_HEIGHT > h)
			scale = (fit_y < 1) ? 1 : fit_y;
		off_x = (w > scale * SRC_WIDTH) ? (w - scale * SRC_WIDTH) / 2 : 0;
		off_y = (h > scale * SRC_HEIGHT) ? (h - scale * SRC_HEIGHT) / 2 : 0;
		for (int sy = 0; sy < scale; sy++) begin
			dy = off_y + row * scale + sy;
			if (dy >= h)
				continue;
			for (int sx = 0; sx < scale; sx++) begin
				dx = off_x + col * scale + sx;
				if (dx >= w)
					break;
				c.col   = dx[WIN_W-1:0];
				c.row   = dy[WIN_W-1:0];
				c.addr  = ADDR_W'(dy * w + dx);
				c.color = color;
				c.last  = 1'b0;
				pending_copies.push_back(c);
				n++;
			end
		end
		if (n > 0)
			pending_copies[pending_copies.size()-1].last = 1'b1;
	endfunction

	task automatic send_pixel(logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
			logic [COLOR_W-1:0] color);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_TDATA_W'({color, row, col});
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_copies(col, row, color);
	endtask

	task automatic send_random_pixel();
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		if ($urandom_range(0, 9) == 0) begin
			col = COL_W'($urandom);
			row = ROW_W'($urandom);
		end else begin
			col = COL_W'($urandom_range(0, SRC_WIDTH - 1));
			row = ROW_W'($urandom_range(0, SRC_HEIGHT - 1));
		end
		send_pixel(col, row, $urandom);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_copies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] value);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			REG_WINDOW_WIDTH:    win_width_reg = value;
			REG_WINDOW_HEIGHT:   win_height_reg = value;
			REG_REQUESTED_SCALE: scale_reg = value[REQ_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_window(int w, int h, int s);
		wait_idle();
		write_reg(REG_WINDOW_WIDTH, CFG_W'(w));
		write_reg(REG_WINDOW_HEIGHT, CFG_W'(h));
		write_reg(REG_REQUESTED_SCALE, CFG_W'(s));
	endtask

	task automatic run_random(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 15) == 0)
				no_idle = ~no_idle;
			send_random_pixel();
		end
		no_idle = 1'b0;
	endtask

	task automatic test_default_extremes();
		send_pixel(9'd0, 8'd0, 32'h0000_0000);
		send_pixel(9'd319, 8'd199, 32'hFFFF_FFFF);
		send_pixel(9'd319, 8'd0, 32'hAAAA_AAAA);
		send_pixel(9'd0, 8'd199, 32'h5555_5555);
		no_idle = 1'b1;
		send_pixel(9'd160, 8'd100, 32'h1234_5678);
		send_pixel(9'd161, 8'd100, 32'h8765_4321);
		no_idle = 1'b0;
	endtask

	task automatic test_out_of_frame();
		send_pixel(9'd320, 8'd0, 32'hDEAD_BEEF);
		send_pixel(9'd0, 8'd200, 32'hCAFE_F00D);
		send_pixel(9'd511, 8'd255, 32'hFFFF_FFFF);
		send_pixel(9'd5, 8'd5, 32'h0F0F_0F0F);
	endtask

	task automatic test_scale_range();
		set_window(4096, 4096, 0);
		send_pixel(9'd319, 8'd199, 32'h0102_0304);
		set_window(4096, 4096, 7);
		send_pixel(9'd319, 8'd199, 32'hF0F0_F0F0);
		send_pixel(9'd0, 8'd0, 32'h0000_0001);
		set_window(1280, 800, 4);
		send_pixel(9'd319, 8'd199, 32'h8000_0000);
	endtask

	task automatic test_zero_window();
		set_window(0, 480, 2);
		send_pixel(9'd10, 8'd10, 32'h1111_1111);
		set_window(640, 0, 2);
		send_pixel(9'd10, 8'd10, 32'h2222_2222);
	endtask

	task automatic test_saturation_and_clipping();
		set_window(8191, 8191, 4);
		send_pixel(9'd319, 8'd199, 32'h3333_3333);
		// window smaller than the frame: whole pixels clipped
		set_window(100, 50, 3);
		send_pixel(9'd99, 8'd49, 32'h4444_4444);
		send_pixel(9'd100, 8'd10, 32'h5555_0000);
		send_pixel(9'd10, 8'd50, 32'h0000_5555);
		set_window(1, 1, 1);
		send_pixel(9'd0, 8'd0, 32'h6666_6666);
		send_pixel(9'd1, 8'd0, 32'h7777_7777);
	endtask

	task automatic test_unknown_register();
		set_window(640, 480, 2);
		write_reg(REG_UNUSED, 13'h1FFF);
		send_pixel(9'd200, 8'd150, 32'h9999_9999);
	endtask

	task automatic test_random();
		set_window(640, 480, 2);
		run_random(50);
		set_window(1280, 800, 4);
		run_random(40);
		set_window(4096, 4096, 7);
		run_random(30);
		set_window(8191, 8191, 3);
		run_random(30);
		set_window(300, 150, 4);
		run_random(40);
		set_window(319, 199, 0);
		run_random(30);
		set_window(960, 600, 3);
		run_random(40);
		set_window(1, 4096, 2);
		run_random(20);
		for (int p = 0; p < 6; p++) begin
			set_window($urandom_range(0, 8191), $urandom_range(0, 8191), $urandom_range(0, 7));
			run_random(20);
		end
	endtask

	// sink side: random back-pressure, compare each copy in arrival order
	initial begin
		int stall;
		blit_copy_t want;
		blit_copy_t got;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			got.col   = m_tdata[11:0];
			got.row   = m_tdata[23:12];
			got.addr  = m_tdata[47:24];
			got.color = m_tdata[79:48];
			got.last  = m_tlast;
			if (pending_copies.size() == 0) begin
				$display("%0t unexpected copy: expected none actual %h", $realtime, got);
				error_count++;
			end else begin
				want = pending_copies.pop_front();
				if (got.col !== want.col) begin
					$display("%0t win_col: expected %h actual %h", $realtime, want.col, got.col);
					error_count++;
				end
				if (got.row !== want.row) begin
					$display("%0t win_row: expected %h actual %h", $realtime, want.row, got.row);
					error_count++;
				end
				if (got.addr !== want.addr) begin
					$display("%0t pixel_address: expected %h actual %h", $realtime,
						want.addr, got.addr);
					error_count++;
				end
				if (got.color !== want.color) begin
					$display("%0t out_color: expected %h actual %h", $realtime,
						want.color, got.color);
					error_count++;
				end
				if (got.last !== want.last) begin
					$display("%0t last_copy: expected %b actual %b", $realtime,
						want.last, got.last);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("integer_upscale_blit_addresser_top_tb failed");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		cfg_wen        = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		error_count    = 0;
		quiet_cycles   = 0;
		no_idle        = 1'b0;
		win_width_reg  = RST_WINDOW_WIDTH;
		win_height_reg = RST_WINDOW_HEIGHT;
		scale_reg      = RST_REQUESTED_SCALE;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_extremes();
		test_out_of_frame();
		test_scale_range();
		test_zero_window();
		test_saturation_and_clipping();
		test_unknown_register();
		test_random();

		wait_idle();
		if (error_count == 0 && pending_copies.size() == 0) begin
			$display("integer_upscale_blit_addresser_top_tb passed");
		end else begin
			$display("integer_upscale_blit_addresser_top_tb failed");
		end
		$finish;
	end

endmodule
